FILE: rtl/core/assert_macros.svh
// assertion macros included by baro_sensor_compensation_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BSC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed in %m");

// condition that must never hold outside reset
`define BSC_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed in %m");

`endif

FILE: rtl/core/bsc_pkg.sv
// package with widths, codes and constants of the barometric compensation block
`default_nettype none

package bsc_pkg;

    localparam int RAW_W     = 24;
    localparam int CAL_W     = 16;
    localparam int VALUE_W   = 32;
    localparam int CFG_IDX_W = 3;

    localparam int TD_W   = 26;
    localparam int MA_W   = 26;
    localparam int MB_W   = 19;
    localparam int MP_W   = MA_W + MB_W;
    localparam int OFF_W  = 40;
    localparam int SENS_W = 36;
    localparam int ACC_W  = 60;
    localparam int DIFF_W = 41;
    localparam int SAT_W  = VALUE_W + 1;

    localparam int REF_T_SHIFT = 8;
    localparam int TEMP_SHIFT  = 23;
    localparam int OFF_SHIFT   = 7;
    localparam int SENS_SHIFT  = 8;
    localparam int C2_SHIFT    = 16;
    localparam int C1_SHIFT    = 15;
    localparam int PROD_SHIFT  = 21;
    localparam int P_SHIFT     = 15;
    localparam int SENS_SPLIT  = 17;
    localparam int P_W         = DIFF_W - P_SHIFT;

    localparam logic signed [VALUE_W-1:0] TEMP_BASE = 32'sd2000;
    localparam logic signed [SAT_W-1:0]   SAT_MAX   = 33'sh0_7FFF_FFFF;
    localparam logic signed [SAT_W-1:0]   SAT_MIN   = 33'sh1_8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS_AT_REF      = 3'd0,
        CFG_OFFSET_AT_REF    = 3'd1,
        CFG_SENS_TEMP_COEF   = 3'd2,
        CFG_OFFSET_TEMP_COEF = 3'd3,
        CFG_REF_TEMPERATURE  = 3'd4,
        CFG_TEMP_SENSITIVITY = 3'd5
    } cfg_idx_t;

    typedef enum logic [0:0] {
        FUNC_TEMP  = 1'b0,
        FUNC_PRESS = 1'b1
    } func_t;

    typedef enum logic [10:0] {
        S_IDLE       = 11'b000_0000_0001,
        S_T_MUL      = 11'b000_0000_0010,
        S_T_FIN      = 11'b000_0000_0100,
        S_P_MUL_OFF  = 11'b000_0000_1000,
        S_P_MUL_SENS = 11'b000_0001_0000,
        S_P_SENS     = 11'b000_0010_0000,
        S_P_MUL_LO   = 11'b000_0100_0000,
        S_P_MUL_HI   = 11'b000_1000_0000,
        S_P_ACC      = 11'b001_0000_0000,
        S_P_FIN      = 11'b010_0000_0000,
        S_SPARE      = 11'b100_0000_0000
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/baro_sensor_compensation_top.sv
// Temperature item: S_T_MUL, then S_T_FIN registers the result; the next item waits for S_IDLE.
// Pressure item: S_P_MUL_OFF through S_P_ACC, then S_P_FIN registers the result.
// Both share the one 26x19 signed multiplier, one product per cycle unless S_T_FIN is stalled.
// A waiting result holds the finishing step until it is taken; no new item enters meanwhile.
// Asynchronous active-low reset clears control, calibration words and stored temperature difference.
`default_nettype none
`include "assert_macros.svh"

module baro_sensor_compensation_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bsc_pkg::CAL_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               func,
    input  logic [bsc_pkg::RAW_W-1:0]          raw_sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               kind,
    output logic signed [bsc_pkg::VALUE_W-1:0] value,
    output logic                               saturated
);
    import bsc_pkg::*;

    state_t state_reg, state_next;

    logic [CAL_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    logic signed [TD_W-1:0] td_reg;
    logic [RAW_W-1:0] raw_reg;
    logic func_reg;
    logic signed [MP_W-1:0] prod_reg;
    logic signed [OFF_W-1:0] off_reg;
    logic signed [SENS_W-1:0] sens_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic out_valid_reg, kind_reg, sat_reg;
    logic signed [VALUE_W-1:0] value_reg;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] mul_p;
    logic signed [TD_W-1:0] dt;
    logic signed [OFF_W-1:0] off_sum;
    logic signed [SENS_W-1:0] sens_sum;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [DIFF_W-1:0] p_diff;
    logic signed [P_W-1:0] p_full;
    logic signed [SAT_W-1:0] p_ext;
    logic signed [VALUE_W-1:0] p_val, t_val;
    logic p_sat;
    logic out_free;
    logic in_xfer;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign saturated = sat_reg;

    // arithmetic datapath around the shared multiplier
    assign dt = $signed({{(TD_W-RAW_W){1'b0}}, raw_reg})
              - $signed({{(TD_W-CAL_W-REF_T_SHIFT){1'b0}}, c5_reg, {REF_T_SHIFT{1'b0}}});

    always_comb
    begin
        mul_a = td_reg;
        mul_b = '0;
        case (state_reg)
            S_T_MUL:
            begin
                mul_a = dt;
                mul_b = $signed({{(MB_W-CAL_W){1'b0}}, c6_reg});
            end
            S_P_MUL_OFF:
            begin
                mul_b = $signed({{(MB_W-CAL_W){1'b0}}, c4_reg});
            end
            S_P_MUL_SENS:
            begin
                mul_b = $signed({{(MB_W-CAL_W){1'b0}}, c3_reg});
            end
            S_P_MUL_LO:
            begin
                mul_a = $signed({{(MA_W-RAW_W){1'b0}}, raw_reg});
                mul_b = $signed({{(MB_W-SENS_SPLIT){1'b0}}, sens_reg[SENS_SPLIT-1:0]});
            end
            S_P_MUL_HI:
            begin
                mul_a = $signed({{(MA_W-RAW_W){1'b0}}, raw_reg});
                mul_b = sens_reg[SENS_W-1:SENS_SPLIT];
            end
            default:
            begin
                mul_a = td_reg;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign t_val = VALUE_W'($signed(prod_reg[MP_W-1:TEMP_SHIFT])) + TEMP_BASE;

    assign off_sum = OFF_W'($signed({1'b0, c2_reg, {C2_SHIFT{1'b0}}}))
                   + OFF_W'($signed(prod_reg[MP_W-1:OFF_SHIFT]));
    assign sens_sum = SENS_W'($signed({1'b0, c1_reg, {C1_SHIFT{1'b0}}}))
                    + SENS_W'($signed(prod_reg[MP_W-1:SENS_SHIFT]));
    assign acc_sum = acc_reg + (ACC_W'(prod_reg) <<< SENS_SPLIT);

    assign p_diff = DIFF_W'($signed(acc_reg[ACC_W-1:PROD_SHIFT])) - DIFF_W'(off_reg);
    assign p_full = p_diff[DIFF_W-1:P_SHIFT];
    assign p_ext  = SAT_W'(p_full);

    always_comb
    begin
        p_sat = 1'b0;
        p_val = VALUE_W'(p_full);
        if (p_ext > SAT_MAX)
        begin
            p_sat = 1'b1;
            p_val = VALUE_W'(SAT_MAX);
        end
        else if (p_ext < SAT_MIN)
        begin
            p_sat = 1'b1;
            p_val = VALUE_W'(SAT_MIN);
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (func == FUNC_TEMP) ? S_T_MUL : S_P_MUL_OFF;
                end
            end
            S_T_MUL:      state_next = S_T_FIN;
            S_T_FIN:      state_next = out_free ? S_IDLE : S_T_FIN;
            S_P_MUL_OFF:  state_next = S_P_MUL_SENS;
            S_P_MUL_SENS: state_next = S_P_SENS;
            S_P_SENS:     state_next = S_P_MUL_LO;
            S_P_MUL_LO:   state_next = S_P_MUL_HI;
            S_P_MUL_HI:   state_next = S_P_ACC;
            S_P_ACC:      state_next = S_P_FIN;
            S_P_FIN:      state_next = out_free ? S_IDLE : S_P_FIN;
            default:      state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            td_reg        <= '0;
            c1_reg        <= '0;
            c2_reg        <= '0;
            c3_reg        <= '0;
            c4_reg        <= '0;
            c5_reg        <= '0;
            c6_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_SENS_AT_REF:      c1_reg <= cfg_data;
                    CFG_OFFSET_AT_REF:    c2_reg <= cfg_data;
                    CFG_SENS_TEMP_COEF:   c3_reg <= cfg_data;
                    CFG_OFFSET_TEMP_COEF: c4_reg <= cfg_data;
                    CFG_REF_TEMPERATURE:  c5_reg <= cfg_data;
                    CFG_TEMP_SENSITIVITY: c6_reg <= cfg_data;
                    default:              ;
                endcase
            end
            if (state_reg == S_T_MUL)
            begin
                td_reg <= dt;
            end
            if ((state_reg == S_T_FIN || state_reg == S_P_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            raw_reg  <= raw_sample;
            func_reg <= func;
        end
        // temperature product must survive a stalled finishing step
        if (state_reg != S_T_FIN)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == S_P_MUL_SENS)
        begin
            off_reg <= off_sum;
        end
        if (state_reg == S_P_SENS)
        begin
            sens_reg <= sens_sum;
        end
        if (state_reg == S_P_MUL_HI)
        begin
            acc_reg <= ACC_W'(prod_reg);
        end
        if (state_reg == S_P_ACC)
        begin
            acc_reg <= acc_sum;
        end
        if (state_reg == S_T_FIN && out_free)
        begin
            kind_reg  <= func_reg;
            value_reg <= t_val;
            sat_reg   <= 1'b0;
        end
        if (state_reg == S_P_FIN && out_free)
        begin
            kind_reg  <= func_reg;
            value_reg <= p_val;
            sat_reg   <= p_sat;
        end
    end

    `BSC_ASSERT(a_temp_start, in_xfer && func == FUNC_TEMP |=> state_reg == S_T_MUL)
    `BSC_ASSERT(a_press_start, in_xfer && func == FUNC_PRESS |=> state_reg == S_P_MUL_OFF)
    `BSC_NEVER(a_sat_on_temp, out_valid_reg && sat_reg && kind_reg == FUNC_TEMP)
    `BSC_ASSERT(a_result_hold, out_valid_reg && !out_ready |=> out_valid_reg && $stable(value_reg))
    `BSC_ASSERT(a_acc_order, state_reg == S_P_ACC |-> $past(state_reg) == S_P_MUL_HI)

endmodule

`default_nettype wire
